@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

@@ sv/fnrgb_pkg.sv @@
// ---------------------------------------------------------------------------
// fnrgb_pkg
// Widths, register codes and the divider stage record of the RGB blend unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fnrgb_pkg;

	localparam int CHAN_W    = 8;
	localparam int NCHAN     = 3;
	localparam int NPIX      = 4;
	localparam int PIX_W     = CHAN_W * NCHAN;
	localparam int WGT_W     = 8;
	localparam int PROD_W    = CHAN_W + WGT_W;
	localparam int ACC_W     = PROD_W + $clog2(NPIX);
	localparam int SUM_W     = ACC_W - CHAN_W;
	localparam int QUO_W     = CHAN_W + 1;
	localparam int DIV_STEPS = 4;

	localparam logic [CHAN_W-1:0] CHAN_MAX = {CHAN_W{1'b1}};

	typedef enum logic [0:0] {
		REG_BLOCKY_MODE       = 1'b0,
		REG_ALLOW_OVEREXPOSED = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0]              divisor;
		logic                          scale;
		logic [NCHAN-1:0][CHAN_W-1:0]  bypass;
		logic [NCHAN-1:0][SUM_W-1:0]   rem;
		logic [NCHAN-1:0][QUO_W-1:0]   quo;
	} div_state_t;

endpackage

@@ sv/fnrgb_div_stage.sv @@
// ---------------------------------------------------------------------------
// fnrgb_div_stage
// One registered stage of the restoring divider: several quotient bits for
// all three channels against the shared divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fnrgb_div_stage (
	input  logic                   clk,
	input  logic                   en,
	input  fnrgb_pkg::div_state_t  d,
	output fnrgb_pkg::div_state_t  q
);
	import fnrgb_pkg::*;

	div_state_t nx;

	always_comb begin
		logic [SUM_W:0] trial;
		nx = d;
		for (int c = 0; c < NCHAN; c++) begin
			for (int k = 0; k < DIV_STEPS; k++) begin
				trial = {nx.rem[c], 1'b0};
				if (trial >= {1'b0, nx.divisor}) begin
					nx.rem[c] = SUM_W'(trial - {1'b0, nx.divisor});
					nx.quo[c] = {nx.quo[c][QUO_W-2:0], 1'b1};
				end else begin
					nx.rem[c] = trial[SUM_W-1:0];
					nx.quo[c] = {nx.quo[c][QUO_W-2:0], 1'b0};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

@@ sv/four_neighbour_rgb_blend_unit.sv @@
// ---------------------------------------------------------------------------
// four_neighbour_rgb_blend_unit
// Blends four neighbouring RGB888 pixels with four weights in units of 1/256.
// Each channel is the weighted sum of the four pixels shifted right by eight.
// In blocky mode the second and third pixels trade places before weighting.
// With overexposure allowed every channel saturates at 255 on its own;
// otherwise, when the brightest channel exceeds 255, all three are rescaled
// to channel * 256 / brightest and clamped to 255, which keeps the hue.
// Weights that are all zero give black. The unit takes one item per clock
// while the output does not stall and delivers one result per item, in
// order. The pipeline has six stages: multiply, add, maximum, two divider
// stages of four quotient bits each, and output register. Every stage
// moves on its own as soon as the stage after it has room, so a stall at
// the output only halts the stages that are full. Configuration is
// written through cfg_we, cfg_index and cfg_data; the user must write it
// only while the unit is idle, as the unit itself does not enforce this.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_neighbour_rgb_blend_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// Configuration write port
	input  logic                                     cfg_we,
	input  fnrgb_pkg::cfg_reg_t                      cfg_index,
	input  logic                                     cfg_data,
	// Pixel channel
	input  logic                                     pix_valid,
	output logic                                     pix_stall,
	input  logic [fnrgb_pkg::PIX_W-1:0]              pixel_a,
	input  logic [fnrgb_pkg::PIX_W-1:0]              pixel_b,
	input  logic [fnrgb_pkg::PIX_W-1:0]              pixel_c,
	input  logic [fnrgb_pkg::PIX_W-1:0]              pixel_d,
	input  logic [fnrgb_pkg::WGT_W-1:0]              weight_a,
	input  logic [fnrgb_pkg::WGT_W-1:0]              weight_b,
	input  logic [fnrgb_pkg::WGT_W-1:0]              weight_c,
	input  logic [fnrgb_pkg::WGT_W-1:0]              weight_d,
	// Result channel
	output logic                                     res_valid,
	input  logic                                     res_stall,
	output logic [fnrgb_pkg::CHAN_W-1:0]             red_out,
	output logic [fnrgb_pkg::CHAN_W-1:0]             green_out,
	output logic [fnrgb_pkg::CHAN_W-1:0]             blue_out
);
	import fnrgb_pkg::*;

	// Configuration registers.
	logic blocky_q;
	logic overexp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocky_q  <= 1'b0;
			overexp_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BLOCKY_MODE:       blocky_q  <= cfg_data;
				REG_ALLOW_OVEREXPOSED: overexp_q <= cfg_data;
				default:               ;
			endcase
		end
	end

	// Per-stage flow control. A stage can load when it is empty or when
	// the stage after it is loading too.
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;

	assign rdy_s6 = !v_s6 || !res_stall;
	assign rdy_s5 = !v_s5 || rdy_s6;
	assign rdy_s4 = !v_s4 || rdy_s5;
	assign rdy_s3 = !v_s3 || rdy_s4;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;

	assign pix_stall = !rdy_s1;
	assign res_valid = v_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pix_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	// Stage 1: the twelve channel-by-weight products. In blocky mode the
	// second and third pixels are exchanged first.
	logic [NPIX-1:0][PIX_W-1:0]  px;
	logic [NPIX-1:0][WGT_W-1:0]  wt;
	logic [NCHAN-1:0][NPIX-1:0][PROD_W-1:0] prod_s1;

	always_comb begin
		px[0] = pixel_a;
		px[1] = blocky_q ? pixel_c : pixel_b;
		px[2] = blocky_q ? pixel_b : pixel_c;
		px[3] = pixel_d;
		wt[0] = weight_a;
		wt[1] = weight_b;
		wt[2] = weight_c;
		wt[3] = weight_d;
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			for (int c = 0; c < NCHAN; c++) begin
				for (int i = 0; i < NPIX; i++) begin
					prod_s1[c][i] <= PROD_W'(px[i][CHAN_W*(NCHAN-c)-1 -: CHAN_W])
						* PROD_W'(wt[i]);
				end
			end
		end
	end

	// Stage 2: the weighted sum of each channel, dropped by eight bits.
	// When every weight is zero all sums are zero, which is already black.
	logic [NCHAN-1:0][SUM_W-1:0] sum_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int c = 0; c < NCHAN; c++) begin
				sum_s2[c] <= SUM_W'((ACC_W'(prod_s1[c][0]) + ACC_W'(prod_s1[c][1])
					+ ACC_W'(prod_s1[c][2]) + ACC_W'(prod_s1[c][3])) >> CHAN_W);
			end
		end
	end

	// Stage 3: brightest channel, the rescale decision, the saturated
	// fallback and the first quotient bit. Since each channel is at most
	// the maximum, the top quotient bit is set only for channels equal to it.
	logic [SUM_W-1:0] max_c;
	div_state_t       init_c;
	div_state_t       div_s3, div_s4, div_s5;

	always_comb begin
		max_c = sum_s2[0];
		if (sum_s2[1] > max_c) max_c = sum_s2[1];
		if (sum_s2[2] > max_c) max_c = sum_s2[2];
		init_c.divisor = max_c;
		init_c.scale   = !overexp_q && (max_c > SUM_W'(CHAN_MAX));
		for (int c = 0; c < NCHAN; c++) begin
			init_c.bypass[c] = (sum_s2[c] > SUM_W'(CHAN_MAX)) ? CHAN_MAX
				: sum_s2[c][CHAN_W-1:0];
			if (sum_s2[c] == max_c) begin
				init_c.rem[c] = '0;
				init_c.quo[c] = QUO_W'(1);
			end else begin
				init_c.rem[c] = sum_s2[c];
				init_c.quo[c] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			div_s3 <= init_c;
		end
	end

	// Stages 4 and 5: the remaining eight quotient bits, four per stage.
	fnrgb_div_stage u_div_s4 (
		.clk (clk),
		.en  (rdy_s4),
		.d   (div_s3),
		.q   (div_s4)
	);

	fnrgb_div_stage u_div_s5 (
		.clk (clk),
		.en  (rdy_s5),
		.d   (div_s4),
		.q   (div_s5)
	);

	// Stage 6: output register. A quotient of 256 belongs to the brightest
	// channel and is clamped to full scale rather than wrapping to zero.
	logic [NCHAN-1:0][CHAN_W-1:0] res_s6;

	always_ff @(posedge clk) begin
		if (rdy_s6) begin
			for (int c = 0; c < NCHAN; c++) begin
				if (!div_s5.scale) begin
					res_s6[c] <= div_s5.bypass[c];
				end else if (div_s5.quo[c][QUO_W-1]) begin
					res_s6[c] <= CHAN_MAX;
				end else begin
					res_s6[c] <= div_s5.quo[c][CHAN_W-1:0];
				end
			end
		end
	end

	assign red_out   = res_s6[0];
	assign green_out = res_s6[1];
	assign blue_out  = res_s6[2];

endmodule

@@ sv/fnrgb_checker.sv @@
// ---------------------------------------------------------------------------
// fnrgb_checker
// Port-level checks on the RGB blend unit, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fnrgb_checker (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     pix_stall,
	input  logic                                     res_valid,
	input  logic                                     res_stall,
	input  logic [fnrgb_pkg::CHAN_W-1:0]             red_out,
	input  logic [fnrgb_pkg::CHAN_W-1:0]             green_out,
	input  logic [fnrgb_pkg::CHAN_W-1:0]             blue_out
);

	logic [fnrgb_pkg::PIX_W-1:0] res_rgb;

	assign res_rgb = {red_out, green_out, blue_out};

	// A held result keeps its value until it is taken.
	`ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(res_rgb))

	// With nothing waiting at the output the pipeline always has room.
	`ASSERT_IMPL(a_empty_takes, clk, arst_n, !res_valid, !pix_stall)

	// Back-pressure at the input only ever comes from a blocked result.
	`ASSERT_IMPL(a_stall_source, clk, arst_n, pix_stall, res_valid && res_stall)

endmodule

bind four_neighbour_rgb_blend_unit fnrgb_checker u_fnrgb_checker (.*);

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for four_neighbour_rgb_blend_unit. Every accepted item
// is run through a behavioural blend predictor and the expected colour is
// queued; each delivered result is compared channel by channel with the
// oldest queued colour. Both channel sides idle at random, and the blend
// mode registers are stepped through all their settings between phases.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import fnrgb_pkg::*;

	localparam int CLK_PERIOD   = 10;
	localparam int PIPE_LATENCY = 6;
	localparam int TAIL_CYCLES  = 4 * PIPE_LATENCY;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_MAX     = 13;
	localparam int PHASE_ITEMS  = 166;

	// One input item: four neighbours and their weights, index 0 is pixel_a.
	typedef struct packed {
		logic [NPIX-1:0][PIX_W-1:0] px;
		logic [NPIX-1:0][WGT_W-1:0] wt;
	} blend_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// Clock and reset. Reset is low from time zero and released once.
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the unit starts at a known value.
	logic              cfg_we    = 1'b0;
	cfg_reg_t          cfg_index = REG_BLOCKY_MODE;
	logic              cfg_data  = 1'b0;
	logic              pix_valid = 1'b0;
	logic              pix_stall;
	logic [PIX_W-1:0]  pixel_a   = '0;
	logic [PIX_W-1:0]  pixel_b   = '0;
	logic [PIX_W-1:0]  pixel_c   = '0;
	logic [PIX_W-1:0]  pixel_d   = '0;
	logic [WGT_W-1:0]  weight_a  = '0;
	logic [WGT_W-1:0]  weight_b  = '0;
	logic [WGT_W-1:0]  weight_c  = '0;
	logic [WGT_W-1:0]  weight_d  = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;

	// Bench copy of the two mode registers, updated as they are written.
	logic mirror_blocky      = 1'b0;
	logic mirror_overexposed = 1'b0;

	// Colours still owed by the unit, oldest first.
	rgb_t expected_rgb [$];

	int failures      = 0;
	int cycle_count   = 0;
	int results_taken = 0;

	// Idle controls. The sender draws a random gap, bounded by gap_max, before
	// each item; the receiver draws a random stall, bounded by stall_max, after
	// each result. Zero in either means that side never idles.
	int gap_max   = IDLE_MAX;
	int stall_max = IDLE_MAX;

	// A long receiver hold-off is requested by bumping hold_requests; the
	// receiver process then counts hold_cycles down on its own.
	int hold_requests = 0;
	int hold_cycles   = 0;
	int hold_seen     = 0;
	int hold_left     = 0;
	int taken_seen    = 0;
	int sink_wait     = 0;

	four_neighbour_rgb_blend_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pixel_a   (pixel_a),
		.pixel_b   (pixel_b),
		.pixel_c   (pixel_c),
		.pixel_d   (pixel_d),
		.weight_a  (weight_a),
		.weight_b  (weight_b),
		.weight_c  (weight_c),
		.weight_d  (weight_d),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a correct run finishes far inside this many cycles.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("four_neighbour_rgb_blend_unit verification failed");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Blend predictor
	// -----------------------------------------------------------------------

	function automatic logic [CHAN_W-1:0] saturate_chan(input int unsigned v);
		return (v > CHAN_MAX) ? CHAN_MAX : CHAN_W'(v);
	endfunction

	// Works out the colour the unit owes for one item under the current mode
	// settings. Sums are kept in 32-bit unsigned integers, which is ample for
	// four products of eight-bit values.
	function automatic rgb_t predict_blend(input blend_item_t it);
		logic [NPIX-1:0][PIX_W-1:0] pix;
		int unsigned acc [NCHAN];
		int unsigned chan;
		int unsigned wgt;
		int unsigned brightest;
		rgb_t res;
		pix = it.px;
		// In blocky mode the second and third neighbours trade places.
		if (mirror_blocky) begin
			pix[1] = it.px[2];
			pix[2] = it.px[1];
		end
		// No weight at all gives black, whatever the pixels hold.
		if (it.wt == '0)
			return '0;
		for (int c = 0; c < NCHAN; c++) begin
			acc[c] = 0;
			for (int i = 0; i < NPIX; i++) begin
				chan = 32'(pix[i][(NCHAN - 1 - c) * CHAN_W +: CHAN_W]);
				wgt = 32'(it.wt[i]);
				acc[c] += chan * wgt;
			end
			acc[c] = acc[c] >> CHAN_W;
		end
		// Without overexposure an over-bright colour is scaled back by its
		// brightest channel; that channel lands on 256 and is clamped below.
		if (!mirror_overexposed) begin
			brightest = acc[0];
			if (acc[1] > brightest)
				brightest = acc[1];
			if (acc[2] > brightest)
				brightest = acc[2];
			if (brightest > CHAN_MAX) begin
				for (int c = 0; c < NCHAN; c++)
					acc[c] = (acc[c] << CHAN_W) / brightest;
			end
		end
		res.red   = saturate_chan(acc[0]);
		res.green = saturate_chan(acc[1]);
		res.blue  = saturate_chan(acc[2]);
		return res;
	endfunction

	// -----------------------------------------------------------------------
	// Result side
	// -----------------------------------------------------------------------

	// Each result taken at a rising edge is checked against the oldest
	// expected colour. A result with nothing owed is a failure as well.
	always @(posedge clk) begin : result_check
		rgb_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_taken++;
			if (expected_rgb.size() == 0) begin
				$error("unexpected result: red_out %0d green_out %0d blue_out %0d",
					red_out, green_out, blue_out);
				failures++;
			end else begin
				want = expected_rgb.pop_front();
				if (red_out !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, red_out);
					failures++;
				end
				if (green_out !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, green_out);
					failures++;
				end
				if (blue_out !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, blue_out);
					failures++;
				end
			end
		end
	end

	// Receiver stall, driven at the falling edge. After each result taken a
	// fresh stall length is drawn; a requested hold-off overrides it and is
	// counted down here, cycle by cycle.
	always @(negedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = hold_cycles;
		end
		if (taken_seen != results_taken) begin
			taken_seen = results_taken;
			sink_wait = (stall_max == 0) ? 0 : $urandom_range(stall_max, 0);
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (sink_wait > 0) begin
			sink_wait--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= 1'b0;
		end
	end

	// -----------------------------------------------------------------------
	// Sender side and register access
	// -----------------------------------------------------------------------

	// Offers one item after a random gap and holds it steady until the unit
	// takes it; the expected colour is queued at the accepting edge.
	task automatic send_pixel_item(input blend_item_t it);
		int gap;
		gap = (gap_max == 0) ? 0 : $urandom_range(gap_max, 0);
		if (gap > 0) begin
			@(negedge clk) pix_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pix_valid <= 1'b1;
		pixel_a   <= it.px[0];
		pixel_b   <= it.px[1];
		pixel_c   <= it.px[2];
		pixel_d   <= it.px[3];
		weight_a  <= it.wt[0];
		weight_b  <= it.wt[1];
		weight_c  <= it.wt[2];
		weight_d  <= it.wt[3];
		do
			@(posedge clk);
		while (pix_stall);
		expected_rgb.push_back(predict_blend(it));
	endtask

	// Stops offering items and waits until every owed colour has arrived.
	task automatic drain_results();
		@(negedge clk) pix_valid <= 1'b0;
		while (expected_rgb.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk) cfg_we <= 1'b0;
		case (idx)
			REG_BLOCKY_MODE:       mirror_blocky = val;
			REG_ALLOW_OVEREXPOSED: mirror_overexposed = val;
			default: ;
		endcase
	endtask

	// Mode changes only ever happen with the unit empty.
	task automatic set_mode(input logic blocky, input logic overexposed);
		drain_results();
		write_reg(REG_BLOCKY_MODE, blocky);
		write_reg(REG_ALLOW_OVEREXPOSED, overexposed);
	endtask

	// -----------------------------------------------------------------------
	// Item generators
	// -----------------------------------------------------------------------

	function automatic blend_item_t make_item(
		input logic [PIX_W-1:0] pa, input logic [PIX_W-1:0] pb,
		input logic [PIX_W-1:0] pc, input logic [PIX_W-1:0] pd,
		input logic [WGT_W-1:0] wa, input logic [WGT_W-1:0] wb,
		input logic [WGT_W-1:0] wc, input logic [WGT_W-1:0] wd);
		blend_item_t it;
		it.px = {pd, pc, pb, pa};
		it.wt = {wd, wc, wb, wa};
		return it;
	endfunction

	// Mostly arbitrary colours, with a share of pure black, white and
	// primaries so that channel extremes turn up often.
	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] p;
		p = PIX_W'($urandom);
		case ($urandom_range(3, 0))
			0: begin
				for (int c = 0; c < NCHAN; c++)
					p[c * CHAN_W +: CHAN_W] = $urandom_range(1, 0) ? CHAN_MAX : '0;
			end
			1: p[$urandom_range(NCHAN - 1, 0) * CHAN_W +: CHAN_W] = CHAN_MAX;
			default: ;
		endcase
		return p;
	endfunction

	// Weights are often true bilinear sets that add up to about one, the
	// way a resampler would issue them; the rest are arbitrary, all zero,
	// all-or-nothing, or heavy enough to push the sums past full scale.
	function automatic logic [NPIX-1:0][WGT_W-1:0] random_weights();
		logic [NPIX-1:0][WGT_W-1:0] w;
		int unsigned fx;
		int unsigned fy;
		fx = $urandom_range(255, 0);
		fy = $urandom_range(255, 0);
		case ($urandom_range(9, 0))
			0, 1, 2, 3: begin
				w[0] = WGT_W'(((255 - fx) * (255 - fy)) / 255);
				w[1] = WGT_W'((fx * (255 - fy)) / 255);
				w[2] = WGT_W'(((255 - fx) * fy) / 255);
				w[3] = WGT_W'((fx * fy) / 255);
			end
			7: w = '0;
			8: begin
				for (int i = 0; i < NPIX; i++)
					w[i] = $urandom_range(1, 0) ? '1 : '0;
			end
			9: begin
				for (int i = 0; i < NPIX; i++)
					w[i] = WGT_W'($urandom_range(255, 200));
			end
			default: w = ($urandom << 16) ^ $urandom;
		endcase
		return w;
	endfunction

	function automatic blend_item_t random_item();
		blend_item_t it;
		for (int i = 0; i < NPIX; i++)
			it.px[i] = random_pixel();
		it.wt = random_weights();
		return it;
	endfunction

	// -----------------------------------------------------------------------
	// Tests
	// -----------------------------------------------------------------------

	// A handful of hand-picked items under each of the four mode settings:
	// zero weights giving black, full white at full weight (the brightest
	// channel reaching 256 on rescale and being clamped), black at full
	// weight, an uneven over-bright colour, a pair of very different middle
	// neighbours that shows whether they were swapped, and an ordinary blend.
	task automatic test_directed_corners();
		blend_item_t corner [6];
		corner[0] = make_item(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
			8'h00, 8'h00, 8'h00, 8'h00);
		corner[1] = make_item(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff,
			8'hff, 8'hff, 8'hff, 8'hff);
		corner[2] = make_item(24'h000000, 24'h000000, 24'h000000, 24'h000000,
			8'hff, 8'hff, 8'hff, 8'hff);
		corner[3] = make_item(24'hff8040, 24'hc02000, 24'hff0000, 24'hffffff,
			8'hff, 8'hff, 8'hff, 8'hff);
		corner[4] = make_item(24'h000000, 24'hff0000, 24'h0000ff, 24'h00ff00,
			8'h00, 8'hff, 8'h01, 8'h00);
		corner[5] = make_item(24'h123456, 24'hfedcba, 24'h5a5a5a, 24'ha5a5a5,
			8'h80, 8'h7f, 8'h01, 8'h01);
		for (int m = 0; m < 4; m++) begin
			set_mode(m[0], m[1]);
			foreach (corner[k])
				send_pixel_item(corner[k]);
		end
	endtask

	// The bulk of the run: phases of random items, the first four covering
	// every mode setting and the rest drawing it at random. Some phases run
	// with no idling on one or both sides so that back-to-back traffic and
	// a free-running output are both seen.
	task automatic test_random_phases();
		for (int p = 0; p < 8; p++) begin
			if (p < 4)
				set_mode(p[0], p[1]);
			else
				set_mode(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
			case (p)
				2: begin
					gap_max   = 0;
					stall_max = 0;
				end
				5: begin
					gap_max   = 0;
					stall_max = IDLE_MAX;
				end
				6: begin
					gap_max   = IDLE_MAX;
					stall_max = 0;
				end
				default: begin
					gap_max   = IDLE_MAX;
					stall_max = IDLE_MAX;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_pixel_item(random_item());
		end
		gap_max   = IDLE_MAX;
		stall_max = IDLE_MAX;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering items back to back, so the pipeline fills and the unit has
	// to stall its input until the output drains.
	task automatic test_backpressure();
		set_mode(1'b0, 1'b0);
		gap_max     = 0;
		hold_cycles = 80;
		hold_requests++;
		repeat (40)
			send_pixel_item(random_item());
		drain_results();
		gap_max = IDLE_MAX;
	endtask

	// The sender stops and waits for every result before offering more, so
	// the unit repeatedly runs dry and starts again from empty.
	task automatic test_sender_pause();
		set_mode(1'b1, 1'b1);
		repeat (3) begin
			repeat (20)
				send_pixel_item(random_item());
			drain_results();
		end
	endtask

	// -----------------------------------------------------------------------
	// Sequence
	// -----------------------------------------------------------------------

	initial begin : run_sequence
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed_corners();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		drain_results();
		// Give a stray extra result the chance to show up before the verdict.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("four_neighbour_rgb_blend_unit verification clean");
		else
			$display("four_neighbour_rgb_blend_unit verification failed");
		$finish;
	end

endmodule
